>>> design/quantized_dot_product_requantize_macros.svh
// Assertion macros used by the top-level design file.
`ifndef QUANTIZED_DOT_PRODUCT_REQUANTIZE_MACROS_SVH
`define QUANTIZED_DOT_PRODUCT_REQUANTIZE_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define QDP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define QDP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/qdp_pkg.sv
package qdp_pkg;

    localparam int ACC_WIDTH_DEFAULT = 48;
    localparam int ELEM_W            = 16;
    localparam int BYTE_W            = 8;
    localparam int OUT_W             = 16;
    localparam int SHIFT_W           = 7;
    localparam int MODE_W            = 2;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 7;
    localparam int EXT_W             = 64;
    localparam int OUT_MAX           = 32767;
    localparam int LEFT_SAT_LIMIT    = 16;

    localparam logic [MODE_W-1:0] MODE_I8_I8   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_I8_I16  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_I16_I16 = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUT_SHIFT    = 1'b0,
        REG_OPERAND_MODE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SHIFT_W-1:0] out_shift;
        logic [MODE_W-1:0]         operand_mode;
    } cfg_t;

endpackage

>>> design/qdp_elem_if.sv
interface qdp_elem_if;
    import qdp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] a_elem;
    logic signed [ELEM_W-1:0] b_elem;
    logic                     last_elem;

    modport source (output valid, output a_elem, output b_elem, output last_elem,
                    input ready);
    modport sink (input valid, input a_elem, input b_elem, input last_elem,
                  output ready);
endinterface

>>> design/qdp_result_if.sv
interface qdp_result_if;
    import qdp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] dot_out;
    logic                    saturated;

    modport source (output valid, output dot_out, output saturated, input ready);
    modport sink (input valid, input dot_out, input saturated, output ready);
endinterface

>>> design/qdp_cfg_if.sv
interface qdp_cfg_if;
    import qdp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/qdp_cfg_regs.sv
module qdp_cfg_regs
(
    input  logic          clk,
    input  logic          rst_n,
    qdp_cfg_if.sink       cfg,
    output qdp_pkg::cfg_t cfg_regs
);
    import qdp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_regs  = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_OUT_SHIFT:
                begin
                    cfg_next.out_shift = signed'(cfg.data[SHIFT_W-1:0]);
                end
                REG_OPERAND_MODE:
                begin
                    cfg_next.operand_mode = cfg.data[MODE_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end
endmodule

>>> design/qdp_mac.sv
module qdp_mac #(
    parameter int ACC_WIDTH = qdp_pkg::ACC_WIDTH_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    qdp_elem_if.sink                    elem,
    input  qdp_pkg::cfg_t               cfg_regs,
    output logic                        sum_valid,
    input  logic                        sum_ready,
    output logic signed [ACC_WIDTH-1:0] sum
);
    import qdp_pkg::*;

    // Operand stage.
    logic                       v1_reg;
    logic signed [ELEM_W-1:0]   a1_reg;
    logic signed [ELEM_W-1:0]   b1_reg;
    logic                       last1_reg;
    logic signed [ELEM_W-1:0]   a1_next;
    logic signed [ELEM_W-1:0]   b1_next;

    // Product stage.
    logic                       v2_reg;
    logic signed [2*ELEM_W-1:0] prod_reg;
    logic                       last2_reg;
    logic signed [2*ELEM_W-1:0] prod_next;

    // Accumulator and finished sum.
    logic signed [ACC_WIDTH-1:0] acc_reg;
    logic signed [ACC_WIDTH-1:0] acc_next;
    logic                        v3_reg;
    logic signed [ACC_WIDTH-1:0] sum_reg;

    logic free1;
    logic free2;
    logic free3;
    logic move1;
    logic move2;
    logic take_elem;

    // A non-last pair only touches the accumulator, so it never waits on the sum register.
    assign free3     = !v3_reg || sum_ready;
    assign move2     = v2_reg && (!last2_reg || free3);
    assign free2     = !v2_reg || move2;
    assign move1     = v1_reg && free2;
    assign free1     = !v1_reg || move1;
    assign take_elem = elem.valid && free1;

    assign elem.ready = free1;
    assign sum_valid  = v3_reg;
    assign sum        = sum_reg;

    always_comb
    begin
        case (cfg_regs.operand_mode)
            MODE_I8_I8:
            begin
                a1_next = ELEM_W'(signed'(elem.a_elem[BYTE_W-1:0]));
                b1_next = ELEM_W'(signed'(elem.b_elem[BYTE_W-1:0]));
            end
            MODE_I8_I16:
            begin
                a1_next = ELEM_W'(signed'(elem.a_elem[BYTE_W-1:0]));
                b1_next = elem.b_elem;
            end
            default:
            begin
                a1_next = elem.a_elem;
                b1_next = elem.b_elem;
            end
        endcase
    end

    assign prod_next = a1_reg * b1_reg;
    assign acc_next  = acc_reg + ACC_WIDTH'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            if (free1)
            begin
                v1_reg <= elem.valid;
            end
            if (free2)
            begin
                v2_reg <= v1_reg;
            end
            if (move2)
            begin
                acc_reg <= last2_reg ? '0 : acc_next;
            end
            if (move2 && last2_reg)
            begin
                v3_reg <= 1'b1;
            end
            else if (sum_ready)
            begin
                v3_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_elem)
        begin
            a1_reg    <= a1_next;
            b1_reg    <= b1_next;
            last1_reg <= elem.last_elem;
        end
        if (move1)
        begin
            prod_reg  <= prod_next;
            last2_reg <= last1_reg;
        end
        if (move2 && last2_reg)
        begin
            sum_reg <= acc_next;
        end
    end
endmodule

>>> design/qdp_requant.sv
module qdp_requant #(
    parameter int ACC_WIDTH = qdp_pkg::ACC_WIDTH_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  qdp_pkg::cfg_t               cfg_regs,
    input  logic                        sum_valid,
    output logic                        sum_ready,
    input  logic signed [ACC_WIDTH-1:0] sum,
    qdp_result_if.source                result
);
    import qdp_pkg::*;

    localparam int                          MAG_W  = $clog2(LEFT_SAT_LIMIT);
    localparam int                          SHAMT_W = $clog2(EXT_W);
    localparam logic signed [ACC_WIDTH-1:0] SAT_HI = ACC_WIDTH'(OUT_MAX);
    localparam logic signed [ACC_WIDTH-1:0] SAT_LO = -SAT_HI - ACC_WIDTH'(1);

    // Shift-and-round stage.
    logic                        v4_reg;
    logic signed [ACC_WIDTH-1:0] q4_reg;
    logic                        inc4_reg;
    logic signed [ACC_WIDTH-1:0] q4_next;
    logic                        inc4_next;

    // Result register.
    logic                        vo_reg;
    logic signed [OUT_W-1:0]     dot_reg;
    logic                        sat_reg;
    logic signed [OUT_W-1:0]     dot_next;
    logic                        sat_next;

    logic signed [EXT_W-1:0]     ext;
    logic signed [EXT_W-1:0]     q64;
    logic [EXT_W-1:0]            low_mask;
    logic [SHAMT_W-1:0]          rshift;
    logic [SHAMT_W-1:0]          half_pos;
    logic [SHIFT_W-1:0]          lmag;
    logic [MAG_W-1:0]            lsh;
    logic signed [ACC_WIDTH-1:0] hi_lim;
    logic signed [ACC_WIDTH-1:0] lo_lim;
    logic signed [ACC_WIDTH-1:0] rounded;

    logic free_o;
    logic move4;
    logic free4;

    assign free_o    = !vo_reg || result.ready;
    assign move4     = v4_reg && free_o;
    assign free4     = !v4_reg || move4;
    assign sum_ready = free4;

    assign result.valid     = vo_reg;
    assign result.dot_out   = dot_reg;
    assign result.saturated = sat_reg;

    always_comb
    begin
        ext      = EXT_W'(sum);
        rshift   = cfg_regs.out_shift[SHAMT_W-1:0];
        half_pos = rshift - SHAMT_W'(1);
        q64      = ext >>> rshift;
        low_mask = (EXT_W'(1) << half_pos) - EXT_W'(1);
        lmag     = SHIFT_W'(-cfg_regs.out_shift);
        lsh      = lmag[MAG_W-1:0];
        hi_lim   = ACC_WIDTH'(OUT_W'(OUT_MAX) >> lsh);
        lo_lim   = -signed'(ACC_WIDTH'((OUT_W + 1)'(OUT_MAX + 1) >> lsh));
        q4_next  = sum;
        inc4_next = 1'b0;
        if (cfg_regs.out_shift > 0)
        begin
            // Round half to even on the bits shifted out.
            q4_next   = q64[ACC_WIDTH-1:0];
            inc4_next = ext[half_pos] && ((|(ext & low_mask)) || q64[0]);
        end
        else if (cfg_regs.out_shift < 0)
        begin
            // Out-of-range values are pushed one past the limit so the next stage flags them.
            if (sum == '0)
            begin
                q4_next = '0;
            end
            else if (lmag >= SHIFT_W'(LEFT_SAT_LIMIT))
            begin
                q4_next = sum[ACC_WIDTH-1] ? SAT_LO - ACC_WIDTH'(1) : SAT_HI + ACC_WIDTH'(1);
            end
            else if (sum > hi_lim)
            begin
                q4_next = SAT_HI + ACC_WIDTH'(1);
            end
            else if (sum < lo_lim)
            begin
                q4_next = SAT_LO - ACC_WIDTH'(1);
            end
            else
            begin
                q4_next = sum <<< lsh;
            end
        end
    end

    always_comb
    begin
        rounded = q4_reg + ACC_WIDTH'(inc4_reg);
        if (rounded > SAT_HI)
        begin
            dot_next = OUT_W'(SAT_HI);
            sat_next = 1'b1;
        end
        else if (rounded < SAT_LO)
        begin
            dot_next = OUT_W'(SAT_LO);
            sat_next = 1'b1;
        end
        else
        begin
            dot_next = rounded[OUT_W-1:0];
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (free4)
            begin
                v4_reg <= sum_valid;
            end
            if (free_o)
            begin
                vo_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_valid && free4)
        begin
            q4_reg   <= q4_next;
            inc4_reg <= inc4_next;
        end
        if (move4)
        begin
            dot_reg <= dot_next;
            sat_reg <= sat_next;
        end
    end
endmodule

>>> design/quantized_dot_product_requantize.sv
// Quantized dot product with requantization.
// The elem channel carries one pair of signed elements per transaction; last_elem
// marks the final pair of a vector. The multiply-accumulate runs in a wide signed
// accumulator; on the last pair the sum is shifted by out_shift (right when
// positive, left when negative), rounded half to even, saturated to int16 and
// sent on the result channel with the saturated flag. The accumulator is then
// cleared for the next vector. Pairs that are not last produce no result.
// Registers on the cfg channel (index 0: out_shift, index 1: operand_mode) are
// to be written only while no vector is in flight (the block does not enforce
// it); cfg.ready is always high. Throughput is one pair per cycle: every stage
// is a single register with short logic, and each stage advances whenever the
// one after it is empty or draining. The last pair passes the operand, product,
// accumulate, shift-and-round and result registers to reach result.valid. When
// the result receiver stalls, the pipeline keeps filling until the stages behind
// the result register are full; pairs that are not last still drain into the
// accumulator. Reset clears all valid bits, the accumulator and both registers.
module quantized_dot_product_requantize #(
    parameter int ACC_WIDTH = qdp_pkg::ACC_WIDTH_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    qdp_cfg_if.sink      cfg,
    qdp_elem_if.sink     elem,
    qdp_result_if.source result
);
    import qdp_pkg::*;

    `include "quantized_dot_product_requantize_macros.svh"

    cfg_t                        cfg_regs;
    logic                        sum_valid;
    logic                        sum_ready;
    logic signed [ACC_WIDTH-1:0] sum;

    qdp_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_regs (cfg_regs)
    );

    qdp_mac #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .elem      (elem),
        .cfg_regs  (cfg_regs),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sum       (sum)
    );

    qdp_requant #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_requant (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_regs  (cfg_regs),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sum       (sum),
        .result    (result)
    );

    // With the result receiver ready, no stage may hold back the input.
    `QDP_ASSERT_NOW(a_no_stall_when_drained, clk, rst_n, result.ready, elem.ready, "elem stalled while result ready")
    // A finished sum waiting on the requantizer must not change.
    `QDP_ASSERT_NEXT(a_sum_held, clk, rst_n, sum_valid && !sum_ready, sum_valid && $stable(sum), "sum changed while stalled")
    // The requantizer takes a sum whenever the result side is free.
    `QDP_ASSERT_NOW(a_sum_taken, clk, rst_n, result.ready, sum_ready, "sum stalled while result ready")
endmodule
